// File: design/rlcm_pkg.sv
package rlcm_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CNT_BITS   = $clog2(VALUE_BITS);
  localparam int unsigned PROD_BITS  = 2 * VALUE_BITS;

  typedef logic [VALUE_BITS-1:0] value_t;

endpackage

// File: design/running_lcm_accumulator_core.sv
// Running least common multiple of 32-bit values. Each input transfer folds
// one value into the running LCM and yields one output transfer carrying the
// updated LCM and an overflow flag; on overflow the running value is kept and
// returned unchanged, and a zero input is ignored. A zero input or the first
// value after reset goes straight to the result. Later values go through one
// shared 34-bit subtractor: a restoring divide tests divisibility, and a value
// that divides the running LCM is then done. Otherwise a binary GCD (one
// subtract, shift or swap per cycle), a second divide and a 32x32 multiply
// follow. The input side is not ready while an item is in work; a finished
// result waits in the output register.
module running_lcm_accumulator_core
  import rlcm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_BITS-1:0] s_axis_tdata,   // [31:0] value
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [VALUE_BITS-1:0] m_axis_tdata,   // [31:0] lcm_out
  output logic                  m_axis_tuser    // [0] overflow
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TEST,
    ST_GCD,
    ST_DIV_QUOT,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e              state_q;
  value_t              lcm_q;
  logic                has_value_q;
  value_t              x_q;
  value_t              rem_q;
  value_t              quo_q;
  value_t              div_q;
  value_t              a_q;
  value_t              b_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [CNT_BITS-1:0] shift_q;
  logic                ovf_q;
  logic                out_valid_q;
  value_t              out_data_q;
  logic                out_ovf_q;

  logic [VALUE_BITS:0]   sub_a;
  logic [VALUE_BITS:0]   sub_b;
  logic [VALUE_BITS+1:0] sub_res;
  logic                  borrow;
  value_t                rem_n;
  value_t                quo_n;
  logic [PROD_BITS-1:0]  prod;
  logic                  in_xfer;
  logic                  out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    if (state_q == ST_GCD) begin
      sub_a = {1'b0, a_q};
      sub_b = {1'b0, b_q};
    end else begin
      sub_a = {rem_q, quo_q[VALUE_BITS-1]};
      sub_b = {1'b0, div_q};
    end
  end

  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = sub_res[VALUE_BITS+1];
  assign rem_n   = borrow ? sub_a[VALUE_BITS-1:0] : sub_res[VALUE_BITS-1:0];
  assign quo_n   = {quo_q[VALUE_BITS-2:0], ~borrow};
  assign prod    = PROD_BITS'(quo_q) * PROD_BITS'(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lcm_q       <= '0;
      has_value_q <= 1'b0;
      x_q         <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      div_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_ovf_q   <= 1'b0;
      cnt_q       <= '0;
      shift_q     <= '0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= lcm_q;
        out_ovf_q   <= ovf_q;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            x_q   <= s_axis_tdata;
            ovf_q <= 1'b0;
            if (s_axis_tdata == '0) begin
              state_q <= ST_DONE;
            end else if (!has_value_q || lcm_q == '0) begin
              lcm_q       <= s_axis_tdata;
              has_value_q <= 1'b1;
              state_q     <= ST_DONE;
            end else begin
              rem_q   <= '0;
              quo_q   <= lcm_q;
              div_q   <= s_axis_tdata;
              cnt_q   <= '0;
              state_q <= ST_DIV_TEST;
            end
          end
        end
        ST_DIV_TEST: begin
          rem_q <= rem_n;
          quo_q <= quo_n;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_BITS'(VALUE_BITS - 1)) begin
            if (rem_n == '0) begin
              state_q <= ST_DONE;
            end else begin
              a_q     <= lcm_q;
              b_q     <= x_q;
              shift_q <= '0;
              state_q <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          priority if (a_q == '0 || b_q == '0) begin
            div_q   <= (a_q | b_q) << shift_q;
            rem_q   <= '0;
            quo_q   <= lcm_q;
            cnt_q   <= '0;
            state_q <= ST_DIV_QUOT;
          end else if (!a_q[0] && !b_q[0]) begin
            a_q     <= a_q >> 1;
            b_q     <= b_q >> 1;
            shift_q <= shift_q + 1'b1;
          end else if (!a_q[0]) begin
            a_q <= a_q >> 1;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else if (!borrow) begin
            a_q <= sub_res[VALUE_BITS-1:0];
          end else begin
            a_q <= b_q;
            b_q <= a_q;
          end
        end
        ST_DIV_QUOT: begin
          rem_q <= rem_n;
          quo_q <= quo_n;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_BITS'(VALUE_BITS - 1)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (prod[PROD_BITS-1:VALUE_BITS] != '0) begin
            ovf_q <= 1'b1;
          end else begin
            lcm_q <= prod[VALUE_BITS-1:0];
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

// File: sim/running_lcm_accumulator_core_tb.sv
module running_lcm_accumulator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlcm_pkg::*;

  localparam int unsigned RESET_CYCLES     = 10;
  localparam int unsigned LONG_HOLD_CYCLES = 1000;
  localparam int unsigned DRAIN_CYCLES     = 250;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned RANDOM_ITEMS     = 1500;
  localparam int unsigned PRESSURE_ITEMS   = 8;
  localparam int unsigned QUIET_ITEMS      = 250;
  localparam longint unsigned TIMEOUT_NS   = 10_000_000;
  localparam logic [63:0] FIELD_MASK       = 64'hFFFF_FFFF;

  typedef struct packed {
    value_t lcm;
    logic   overflow;
  } lcm_result_t;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   s_axis_tvalid = 1'b0;
  logic   s_axis_tready;
  value_t s_axis_tdata  = '0;
  logic   m_axis_tvalid;
  logic   m_axis_tready = 1'b0;
  value_t m_axis_tdata;
  logic   m_axis_tuser;

  logic [63:0] lcm_state = '0;
  logic        lcm_seen  = 1'b0;
  lcm_result_t lcm_expected_q[$];

  logic quiet_mode  = 1'b0;
  logic hold_active = 1'b0;

  int unsigned error_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned zero_count     = 0;
  int unsigned growth_count   = 0;
  int unsigned overflow_count = 0;
  int unsigned results_seen   = 0;

  running_lcm_accumulator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic lcm_result_t fold_value(value_t v);
    logic [63:0] x;
    logic [63:0] limit;
    logic [63:0] q;
    lcm_result_t res;
    x = 64'(v) & FIELD_MASK;
    limit = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    res.overflow = 1'b0;
    if (x != 0) begin
      if (x > limit) begin
        res.overflow = 1'b1;
      end else if (!lcm_seen || lcm_state == 0) begin
        lcm_state = x;
        lcm_seen  = 1'b1;
      end else if (lcm_state % x != 0) begin
        q = lcm_state / gcd64(lcm_state, x);
        if (q > limit / x) begin
          res.overflow = 1'b1;
        end else begin
          lcm_state = q * x;
          growth_count++;
        end
      end
    end
    if (res.overflow) overflow_count++;
    res.lcm = value_t'(lcm_state & FIELD_MASK);
    return res;
  endfunction

  function automatic value_t random_value();
    int unsigned kind;
    logic [63:0] d;
    logic [63:0] m;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      if (!lcm_seen) return value_t'($urandom_range(1, 64));
      d = lcm_state / gcd64(lcm_state, 64'($urandom));
      return value_t'(d);
    end else if (kind < 45) begin
      d = lcm_seen ? lcm_state / gcd64(lcm_state, 64'($urandom)) : 64'd1;
      m = d * 64'($urandom_range(2, 40));
      return value_t'((m > FIELD_MASK) ? d : m);
    end else if (kind < 55) begin
      return value_t'($urandom_range(1, 255));
    end else if (kind < 63) begin
      return '0;
    end else if (kind < 70) begin
      case ($urandom_range(0, 4))
        0: return value_t'(1);
        1: return value_t'(32'hFFFF_FFFF);
        2: return value_t'(32'h8000_0000);
        3: return value_t'(32'd1 << $urandom_range(0, 31));
        default: return value_t'(~(32'd1 << $urandom_range(0, 31)));
      endcase
    end
    return value_t'($urandom);
  endfunction

  task automatic send_value(input value_t v);
    int unsigned gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    lcm_expected_q.push_back(fold_value(v));
    items_sent++;
    if (v == '0) zero_count++;
  endtask

  task automatic test_directed();
    value_t seq[$];
    seq = '{value_t'(0), value_t'(1), value_t'(1), value_t'(2), value_t'(3),
            value_t'(4), value_t'(6), value_t'(0), value_t'(5), value_t'(7),
            value_t'(32'hFFFF_FFFF), value_t'(32'h8000_0000), value_t'(11),
            value_t'(13), value_t'(16), value_t'(17), value_t'(32'hFFFF_FFFB),
            value_t'(4084080), value_t'(2042040), value_t'(1),
            value_t'(32'h0001_0000), value_t'(0)};
    foreach (seq[i]) send_value(seq[i]);
  endtask

  task automatic test_random_mix();
    repeat (RANDOM_ITEMS) send_value(random_value());
  endtask

  task automatic test_output_backpressure();
    hold_active <= 1'b1;
    repeat (PRESSURE_ITEMS) send_value(random_value());
  endtask

  task automatic test_back_to_back();
    quiet_mode = 1'b1;
    repeat (QUIET_ITEMS) send_value(random_value());
  endtask

  // Sink side: random stalls, plus one long hold-off on request.
  int unsigned sink_gap   = 0;
  int unsigned hold_count = 0;

  always @(posedge clk_i) begin
    if (hold_active) begin
      m_axis_tready <= 1'b0;
      if (hold_count == LONG_HOLD_CYCLES - 1) begin
        hold_count = 0;
        hold_active <= 1'b0;
      end else begin
        hold_count++;
      end
    end else if (sink_gap > 0) begin
      m_axis_tready <= 1'b0;
      sink_gap--;
    end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      sink_gap = $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    lcm_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (lcm_expected_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected result lcm=%0d overflow=%0b", m_axis_tdata,
                   m_axis_tuser);
      end else begin
        want = lcm_expected_q.pop_front();
        if (m_axis_tdata !== want.lcm || m_axis_tuser !== want.overflow) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: result %0d: expected lcm=%0d overflow=%0b, got lcm=%0d overflow=%0b",
                     results_seen, want.lcm, want.overflow, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix();
    test_output_backpressure();
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    while (lcm_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d values (%0d zero), %0d LCM growth steps, %0d overflows,",
             items_sent, zero_count, growth_count, overflow_count);
    $display("%0d results checked, final running LCM %0d, %0d errors",
             results_seen, lcm_state, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TIMEOUT: %0d results still pending", lcm_expected_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: running_lcm_accumulator_core.f
design/rlcm_pkg.sv
design/running_lcm_accumulator_core.sv
sim/running_lcm_accumulator_core_tb.sv
